>>> hw/rtl/mlar_pkg.sv
// ----------------------------------------------------------------------------
// mlar_pkg: shared constants and types of the multi-line route finder
// Sizes of the cost store and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mlar_pkg;

  localparam int unsigned MAX_LINES   = 8;
  localparam int unsigned MAX_COLUMNS = 32;
  localparam int unsigned COST_W      = 24;
  localparam int unsigned LINE_W      = 3;
  localparam int unsigned COL_W       = 5;
  localparam int unsigned ADDR_W      = COL_W + LINE_W;
  localparam int unsigned STEP_W      = 18;   // station + travel + transfer

  // Commands issued by the controller, at most one per cycle.
  typedef struct packed {
    logic accept;     // take the input item and start its store read
    logic calc;       // add-compare-select and store update
    logic scan_rd;    // read one final-column cost
    logic scan_cmp;   // compare it against the best so far
    logic walk_rd;    // read the entry of the route at the current column
    logic walk_load;  // move that entry into the output register
  } mlar_cmd_t;

  // Status reported by the datapath.
  typedef struct packed {
    logic item_ignore;  // offered item is out of range or has no open problem
    logic item_trig;    // accepted item completes the problem
    logic scan_last;    // scan is at the last line in use
    logic walk_last;    // route walk is at column zero
    logic out_free;     // output register can take a result this cycle
  } mlar_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/mlar_ctrl.sv
// ----------------------------------------------------------------------------
// mlar_ctrl: sequencer of the multi-line route finder
// Steps each item through its store read and update, then runs the final
// scan and the route walk once a problem is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module mlar_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  output logic                     s_tready_o,
  input  wire mlar_pkg::mlar_sts_t sts_i,
  output mlar_pkg::mlar_cmd_t      cmd_o
);
  import mlar_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_WALK_RD,
    ST_WALK_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   tready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i && tready_q && !sts_i.item_ignore) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = sts_i.item_trig ? ST_SCAN_RD : ST_IDLE;
      end
      ST_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = sts_i.scan_last ? ST_WALK_RD : ST_SCAN_RD;
      end
      ST_WALK_RD: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = ST_WALK_LOAD;
      end
      ST_WALK_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.walk_load = 1'b1;
          state_d         = sts_i.walk_last ? ST_IDLE : ST_WALK_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tready_q <= 1'b1;
    end else begin
      state_q  <= state_d;
      tready_q <= (state_d == ST_IDLE);
    end
  end

  assign s_tready_o = tready_q;

endmodule

`default_nettype wire

>>> hw/rtl/mlar_dp.sv
// ----------------------------------------------------------------------------
// mlar_dp: datapath of the multi-line route finder
// Holds the cost and back-pointer stores, the running minimum, the column
// counter, the traceback registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlar_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mlar_pkg::mlar_cmd_t         cmd_i,
  output mlar_pkg::mlar_sts_t              sts_o,
  input  wire logic [mlar_pkg::LINE_W-1:0] last_line_i,
  input  wire logic [55:0]                 s_tdata_i,
  input  wire logic                        s_tuser_i,
  input  wire logic                        s_tlast_i,
  output logic                             m_tvalid_o,
  input  wire logic                        m_tready_i,
  output logic [31:0]                      m_tdata_o,
  output logic                             m_tlast_o
);
  import mlar_pkg::*;

  // Input fields.
  logic [15:0]       in_station, in_travel, in_transfer;
  logic [LINE_W-1:0] in_dest, in_src;
  logic [STEP_W-1:0] in_step;

  assign in_station  = s_tdata_i[15:0];
  assign in_travel   = s_tdata_i[31:16];
  assign in_transfer = s_tdata_i[47:32];
  assign in_dest     = s_tdata_i[50:48];
  assign in_src      = s_tdata_i[53:51];

  // The edge costs are summed ahead of the store read. Saturating once at the
  // end gives the same value as saturating after each addition.
  assign in_step = STEP_W'(in_station) + STEP_W'(in_travel) +
                   ((in_src != in_dest) ? STEP_W'(in_transfer) : STEP_W'(0));

  // Stores.
  logic [COST_W-1:0] cost_mem [MAX_COLUMNS*MAX_LINES];
  logic [LINE_W-1:0] back_mem [MAX_COLUMNS*MAX_LINES];
  logic [COST_W-1:0] rd_cost_q;
  logic [LINE_W-1:0] rd_back_q;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [COST_W-1:0] wr_cost;
  logic [LINE_W-1:0] wr_back;

  // Control state.
  logic [COL_W-1:0]  col_q, col_d;
  logic [COST_W-1:0] run_min_q, run_min_d;
  logic [LINE_W-1:0] run_arg_q, run_arg_d;
  logic              run_valid_q, run_valid_d;
  logic              out_valid_q, out_valid_d;

  // Item and traceback payload.
  logic [LINE_W-1:0] dest_q, src_q;
  logic              first_q, trig_q;
  logic [15:0]       station_q;
  logic [STEP_W-1:0] step_q;
  logic [LINE_W-1:0] scan_l_q;
  logic [COST_W-1:0] scan_best_q;
  logic [LINE_W-1:0] tl_q;
  logic [COL_W-1:0]  tc_q;
  logic [COST_W-1:0] out_cost_q;
  logic [LINE_W-1:0] out_line_q;
  logic [COL_W-1:0]  out_col_q;
  logic              out_last_q;

  logic              in_trig;
  logic [COL_W-1:0]  col_m1;
  logic [COST_W:0]   sum;
  logic [COST_W-1:0] cand, new_min;
  logic [LINE_W-1:0] new_arg, back_fix;
  logic              win, src_done, dest_done;

  assign col_m1 = col_q - COL_W'(1);

  assign in_trig = (in_dest == last_line_i) &&
                   (s_tuser_i ? s_tlast_i :
                    ((in_src == last_line_i) &&
                     (s_tlast_i || (col_q == COL_W'(MAX_COLUMNS - 1)))));

  assign sts_o.item_ignore = (in_dest > last_line_i) ||
                             (!s_tuser_i && ((in_src > last_line_i) || (col_q == '0)));
  assign sts_o.item_trig   = trig_q;
  assign sts_o.scan_last   = (scan_l_q == last_line_i);
  assign sts_o.walk_last   = (tc_q == '0);
  assign sts_o.out_free    = !out_valid_q || m_tready_i;

  // Add-compare-select.
  assign sum       = {1'b0, rd_cost_q} + (COST_W+1)'(step_q);
  assign cand      = sum[COST_W] ? '1 : sum[COST_W-1:0];
  assign win       = !run_valid_q || (cand < run_min_q) ||
                     ((cand == run_min_q) && (src_q < run_arg_q));
  assign new_min   = win ? cand : run_min_q;
  assign new_arg   = win ? src_q : run_arg_q;
  assign src_done  = (src_q == last_line_i);
  assign dest_done = (dest_q == last_line_i);
  assign back_fix  = ({1'b0, rd_back_q} >= (LINE_W+1)'(MAX_LINES)) ? '0 : rd_back_q;

  // Store port selection.
  always_comb begin
    rd_en   = cmd_i.accept || cmd_i.scan_rd || cmd_i.walk_rd;
    rd_addr = {tc_q, tl_q};
    if (cmd_i.accept) begin
      rd_addr = {col_m1, in_src};
    end else if (cmd_i.scan_rd) begin
      rd_addr = {tc_q, scan_l_q};
    end
    wr_en   = cmd_i.calc && (first_q || src_done);
    wr_addr = first_q ? {COL_W'(0), dest_q} : {col_q, dest_q};
    wr_cost = first_q ? COST_W'(station_q) : new_min;
    wr_back = first_q ? dest_q : new_arg;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_cost_q <= cost_mem[rd_addr];
      rd_back_q <= back_mem[rd_addr];
    end
    if (wr_en) begin
      cost_mem[wr_addr] <= wr_cost;
      back_mem[wr_addr] <= wr_back;
    end
  end

  // Column counter, running minimum and output valid.
  always_comb begin
    col_d       = col_q;
    run_min_d   = run_min_q;
    run_arg_d   = run_arg_q;
    run_valid_d = run_valid_q;
    out_valid_d = out_valid_q && !m_tready_i;
    if (cmd_i.calc) begin
      if (first_q || src_done) begin
        run_min_d   = '1;
        run_arg_d   = '0;
        run_valid_d = 1'b0;
      end else begin
        run_min_d   = new_min;
        run_arg_d   = new_arg;
        run_valid_d = 1'b1;
      end
      if (first_q) begin
        col_d = (dest_done && !trig_q) ? COL_W'(1) : COL_W'(0);
      end else if (src_done && dest_done && !trig_q) begin
        col_d = col_q + COL_W'(1);
      end
    end
    if (cmd_i.walk_load) begin
      out_valid_d = 1'b1;
      if (tc_q == '0) begin
        col_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      run_min_q   <= '1;
      run_arg_q   <= '0;
      run_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      run_min_q   <= run_min_d;
      run_arg_q   <= run_arg_d;
      run_valid_q <= run_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dest_q    <= in_dest;
      src_q     <= in_src;
      first_q   <= s_tuser_i;
      trig_q    <= in_trig;
      station_q <= in_station;
      step_q    <= in_step;
    end
    if (cmd_i.calc && trig_q) begin
      scan_l_q <= '0;
      tc_q     <= first_q ? COL_W'(0) : col_q;
    end
    if (cmd_i.scan_cmp) begin
      if ((scan_l_q == '0) || (rd_cost_q < scan_best_q)) begin
        scan_best_q <= rd_cost_q;
        tl_q        <= scan_l_q;
      end
      scan_l_q <= scan_l_q + LINE_W'(1);
    end
    if (cmd_i.walk_load) begin
      out_cost_q <= rd_cost_q;
      out_line_q <= tl_q;
      out_col_q  <= tc_q;
      out_last_q <= (tc_q == '0);
      tl_q       <= back_fix;
      if (tc_q != '0) begin
        tc_q <= tc_q - COL_W'(1);
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_col_q, out_line_q, out_cost_q};
  assign m_tlast_o  = out_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/multi_line_assembly_route_dp.sv
// ----------------------------------------------------------------------------
// multi_line_assembly_route_dp: cheapest route through a grid of lines
// Dynamic-programming route finder with traceback over up to 32 columns and
// 8 lines, an APB register for the line count and stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

// Items come in column by column: the entry column (tuser set) carries one
// item per line, every later column one item per pair of destination line and
// source line, sources innermost, and tlast marks the items of the last
// column. An accepted item goes first through the registered read of the
// previous column's best cost from the cost store, then through the saturating
// add-compare-select and the store write; an item that is out of range, or
// that arrives with no open problem, is dropped in its transfer cycle. When a
// column marked last (or column 31) completes, the block stops accepting
// items and traces back: it scans the store, a read and a compare per line in
// use, for the cheapest final line, then walks the route, a read and a load per
// column, each result waiting in the output register for its transfer. Results
// come last column first, tlast on the result of column zero. Input transfers
// resume as soon as the column zero result is loaded. line_count is written at
// byte address 0; write it only while the block is idle.

module multi_line_assembly_route_dp (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream. tdata from bit 0: station_cost[15:0], travel_cost[15:0],
  // transfer_cost[15:0], dest_line[2:0], source_line[2:0], two zero bits.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,
  // tuser: first_column.
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tlast,   // final_column
  // Result stream. tdata from bit 0: route_cost[23:0], route_line[2:0],
  // column_index[4:0].
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast,   // last_of_run
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mlar_pkg::*;

  localparam logic [3:0] LC_RESET = 4'd2;

  logic [3:0]        lc_q;
  logic [3:0]        lc_m1;
  logic [LINE_W-1:0] last_line;
  mlar_cmd_t         cmd;
  mlar_sts_t         sts;

  // The line count register. Index 0 sits in the lower word of the address
  // range; a write to the upper word has no effect.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= LC_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      lc_q <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {28'd0, lc_q} : 32'd0;

  // Highest line in use: a count of zero acts as one line, and a count above
  // the line limit acts as the limit.
  assign lc_m1 = lc_q - 4'd1;

  always_comb begin
    if (lc_q == 4'd0) begin
      last_line = '0;
    end else if (lc_q > 4'(MAX_LINES)) begin
      last_line = LINE_W'(MAX_LINES - 1);
    end else begin
      last_line = lc_m1[LINE_W-1:0];
    end
  end

  mlar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mlar_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .last_line_i (last_line),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast)
  );

  // A kept item occupies the block for its update cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !sts.item_ignore |=> !s_axis_tready)
    else $error("input accepted during an item update");

  // The controller issues at most one command per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  // The result that ends a route describes column zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[31:27] == 5'd0))
    else $error("route end flagged on a column other than zero");

  // A route walk never loads the output register while a result is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !cmd.walk_load)
    else $error("result overwritten before its transfer");

endmodule

`default_nettype wire
